// ===== rtl/atc_pkg.sv =====
// ============================================================================
// Associative tag cache package
// Shared constants, codes, types and the LFSR step function for the tag cache.
// ============================================================================
`default_nettype none

package atc_pkg;

    // Number of slots in the tag store.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int ID_W    = 31;
    localparam int SLOT_W  = 4;

    // Victim generator: 16-bit Galois LFSR.
    localparam int                LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

    // Reciprocal for reducing the LFSR value modulo ENTRIES:
    // floor(x / ENTRIES) == (x * MOD_RECIP) >> MOD_SHIFT for every 16-bit x.
    localparam int              MOD_SHIFT   = 32;
    localparam longint unsigned MOD_RECIP_L = ((64'd1 << MOD_SHIFT) + ENTRIES - 1) / ENTRIES;
    localparam logic [31:0]     MOD_RECIP   = 32'(MOD_RECIP_L);
    localparam int              PROD_W      = LFSR_W + 32;

    // Operation codes.
    localparam logic OP_STORE    = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    // Response status codes.
    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_STORED    = 3'd2,
        ST_EVICTED   = 3'd3,
        ST_REFRESHED = 3'd4
    } atc_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take a new request
        logic lookup;   // compare tags and register the search results
        logic update;   // commit state and load the response register
    } atc_cmd_t;

    // One step of the Galois LFSR.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0])
        begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/atc_if.sv =====
// ============================================================================
// Associative tag cache channel interfaces
// Valid/ready channels for requests, responses and the mode register write.
// ============================================================================
`default_nettype none

// Request channel: one store or retrieve request.
interface atc_req_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [atc_pkg::ID_W-1:0] message_id;

    modport source (output valid, output operation, output message_id, input ready);
    modport sink   (input valid, input operation, input message_id, output ready);
endinterface

// Response channel: one response per request.
interface atc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [atc_pkg::SLOT_W-1:0] slot;
    logic [atc_pkg::ID_W-1:0]   evicted_id;

    modport source (output valid, output status, output slot, output evicted_id,
                    input ready);
    modport sink   (input valid, input status, input slot, input evicted_id,
                    output ready);
endinterface

// Configuration write channel for the replacement mode register.
interface atc_cfg_if;
    logic valid;
    logic ready;
    logic replace_mode;

    modport source (output valid, output replace_mode, input ready);
    modport sink   (input valid, input replace_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/assoc_tag_cache_lru_random.sv =====
// ============================================================================
// Associative tag cache with LRU or random replacement
// Sixteen-slot fully associative store of message identifiers.
// ============================================================================
// req carries one request (operation: 0 store, 1 retrieve; message_id), and
// rsp returns one response per request, in order: status, slot and, after an
// eviction, the evicted identifier. cfg writes replace_mode (0 least recently
// used, 1 pseudo-random victim); it is always ready and should be written only
// while no request is open.
// A request is captured at the accepting edge, its tags are compared in the
// next cycle and the state is committed in the update step, once the
// response register is free; the commit loads the response register and
// raises rsp.valid. The next request is taken at the commit edge at the
// earliest, so a new request is never accepted during a lookup.
// Reset empties every slot, returns the mode to least recently used and seeds
// the victim LFSR with one. No clearing pass is needed.
// While rsp.ready is low a finished response is held; one further request is
// accepted and looked up, then waits for the response register to drain.
// ============================================================================
`default_nettype none

module assoc_tag_cache_lru_random (
    input  wire logic  clk,
    input  wire logic  rst_n,
    atc_req_if.sink    req,
    atc_rsp_if.source  rsp,
    atc_cfg_if.sink    cfg
);

    atc_pkg::atc_cmd_t cmd;

    // The mode register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencing and handshakes.
    atc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Tag store and response payload.
    atc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_operation  (req.operation),
        .req_message_id (req.message_id),
        .cfg_we         (cfg.valid),
        .cfg_mode       (cfg.replace_mode),
        .rsp_status     (rsp.status),
        .rsp_slot       (rsp.slot),
        .rsp_evicted_id (rsp.evicted_id)
    );

endmodule

`default_nettype wire

// ===== rtl/atc_ctrl.sv =====
// ============================================================================
// Associative tag cache controller
// Sequences capture, lookup and update of each request and owns the
// handshake flags of the request and response channels.
// ============================================================================
`default_nettype none

module atc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output atc_pkg::atc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_UPDATE = 3'b100
    } atc_state_t;

    atc_state_t state_reg;
    atc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    // The response register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || rsp_ready;

    // A new request is taken when idle, or at the edge that commits the current one.
    always_comb
    begin
        req_ready = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
        accept    = req_valid && req_ready;
        cmd.capture = accept;
        cmd.lookup  = (state_reg == S_LOOKUP);
        cmd.update  = (state_reg == S_UPDATE) && out_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = accept ? S_LOOKUP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A commit never overwrites a response that is still waiting.
    a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!out_valid_reg || rsp_ready))
        else $error("commit while response register is occupied");

    // A captured request is looked up in the following cycle.
    a_capture_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_LOOKUP))
        else $error("captured request not looked up");

    // Lookup is always followed by the update step.
    a_lookup_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |=> (state_reg == S_UPDATE))
        else $error("lookup not followed by update");

    // A response only appears after a commit.
    a_rsp_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.update))
        else $error("response raised without a commit");
`endif

endmodule

`default_nettype wire

// ===== rtl/atc_dp.sv =====
// ============================================================================
// Associative tag cache datapath
// Tag store, recency ranks, victim LFSR, parallel tag match and the
// response register.
// ============================================================================
`default_nettype none

module atc_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire atc_pkg::atc_cmd_t           cmd,
    input  wire logic                        req_operation,
    input  wire logic [atc_pkg::ID_W-1:0]    req_message_id,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_mode,
    output logic [2:0]                       rsp_status,
    output logic [atc_pkg::SLOT_W-1:0]       rsp_slot,
    output logic [atc_pkg::ID_W-1:0]         rsp_evicted_id
);

    localparam int N = atc_pkg::ENTRIES;
    localparam int IW = atc_pkg::IDX_W;
    localparam int RW = atc_pkg::RANK_W;
    localparam int LW = atc_pkg::LFSR_W;
    localparam logic [RW-1:0] RANK_OLDEST = RW'(N - 1);
    localparam logic [LW-1:0] ENTRIES_L   = LW'(N);

    // Architectural state.
    logic                       mode_reg;
    logic [LW-1:0]              lfsr_reg;
    logic                       valid_reg [N];
    logic [RW-1:0]              rank_reg  [N];
    logic [atc_pkg::ID_W-1:0]   id_reg    [N];

    // Captured request.
    logic                       op_reg;
    logic [atc_pkg::ID_W-1:0]   req_id_reg;

    // Registered search results.
    logic                       hit_reg;
    logic [IW-1:0]              hit_idx_reg;
    logic                       empty_reg;
    logic [IW-1:0]              empty_idx_reg;
    logic [IW-1:0]              lru_idx_reg;
    logic [LW-1:0]              step_reg;
    logic [LW-1:0]              quot_reg;

    // Response register.
    atc_pkg::atc_status_t       status_reg;
    logic [atc_pkg::SLOT_W-1:0] slot_reg;
    logic [atc_pkg::ID_W-1:0]   evict_reg;

    // Search results before registering.
    logic                       hit_c;
    logic [IW-1:0]              hit_idx_c;
    logic                       empty_c;
    logic [IW-1:0]              empty_idx_c;
    logic [IW-1:0]              lru_idx_c;
    logic [LW-1:0]              step_c;
    logic [atc_pkg::PROD_W-1:0] prod_c;

    // Commit decisions.
    logic [LW-1:0]              rem_c;
    logic [IW-1:0]              rnd_idx;
    logic [IW-1:0]              victim;
    logic                       touch_en;
    logic [IW-1:0]              touch_idx;
    logic                       touch_was;
    logic [RW-1:0]              touch_rank;
    logic                       wr_en;
    logic [IW-1:0]              wr_idx;
    logic                       lfsr_adv;
    atc_pkg::atc_status_t       status_next;
    logic [IW-1:0]              slot_next;
    logic [atc_pkg::ID_W-1:0]   evict_next;
    logic                       valid_next [N];
    logic [RW-1:0]              rank_next  [N];

    // Parallel tag match, first empty slot and the oldest slot.
    // Scanning downwards leaves the lowest index in each result.
    always_comb
    begin
        hit_c       = 1'b0;
        hit_idx_c   = '0;
        empty_c     = 1'b0;
        empty_idx_c = '0;
        lru_idx_c   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (id_reg[i] == req_id_reg))
            begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
            if (!valid_reg[i])
            begin
                empty_c     = 1'b1;
                empty_idx_c = IW'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == RANK_OLDEST))
            begin
                lru_idx_c = IW'(i);
            end
        end
    end

    // Next LFSR value and its quotient by the slot count.
    always_comb
    begin
        step_c = atc_pkg::lfsr_step(lfsr_reg);
        prod_c = atc_pkg::PROD_W'(step_c) * atc_pkg::PROD_W'(atc_pkg::MOD_RECIP);
    end

    // Random victim: remainder of the stepped LFSR value.
    always_comb
    begin
        rem_c   = step_reg - LW'(quot_reg * ENTRIES_L);
        rnd_idx = rem_c[IW-1:0];
        victim  = mode_reg ? rnd_idx : lru_idx_reg;
    end

    // Decide the outcome of the request.
    always_comb
    begin
        touch_en    = 1'b0;
        touch_idx   = '0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        lfsr_adv    = 1'b0;
        status_next = atc_pkg::ST_MISS;
        slot_next   = '0;
        evict_next  = '0;
        if (op_reg == atc_pkg::OP_RETRIEVE)
        begin
            if (hit_reg)
            begin
                touch_en    = 1'b1;
                touch_idx   = hit_idx_reg;
                status_next = atc_pkg::ST_HIT;
                slot_next   = hit_idx_reg;
            end
        end
        else if (hit_reg)
        begin
            touch_en    = 1'b1;
            touch_idx   = hit_idx_reg;
            status_next = atc_pkg::ST_REFRESHED;
            slot_next   = hit_idx_reg;
        end
        else if (empty_reg)
        begin
            touch_en    = 1'b1;
            touch_idx   = empty_idx_reg;
            wr_en       = 1'b1;
            wr_idx      = empty_idx_reg;
            status_next = atc_pkg::ST_STORED;
            slot_next   = empty_idx_reg;
        end
        else
        begin
            touch_en    = 1'b1;
            touch_idx   = victim;
            wr_en       = 1'b1;
            wr_idx      = victim;
            lfsr_adv    = mode_reg;
            status_next = atc_pkg::ST_EVICTED;
            slot_next   = victim;
            evict_next  = id_reg[victim];
        end
    end

    // Recency update: the touched slot becomes rank zero and the slots that
    // were younger than it (all valid slots on a fresh fill) age by one.
    always_comb
    begin
        touch_was  = valid_reg[touch_idx];
        touch_rank = rank_reg[touch_idx];
        for (int i = 0; i < N; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (touch_en)
            begin
                if (IW'(i) == touch_idx)
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i] && (!touch_was || (rank_reg[i] < touch_rank)))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
    end

    // Control state: mode, LFSR, valid bits and ranks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lfsr_reg <= atc_pkg::LFSR_SEED;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_mode;
            end
            if (cmd.update)
            begin
                if (lfsr_adv)
                begin
                    lfsr_reg <= step_reg;
                end
                for (int i = 0; i < N; i++)
                begin
                    valid_reg[i] <= valid_next[i];
                    rank_reg[i]  <= rank_next[i];
                end
            end
        end
    end

    // Payload registers: tags, request, search results and response.
    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_en)
        begin
            id_reg[wr_idx] <= req_id_reg;
        end
        if (cmd.capture)
        begin
            op_reg     <= req_operation;
            req_id_reg <= req_message_id;
        end
        if (cmd.lookup)
        begin
            hit_reg       <= hit_c;
            hit_idx_reg   <= hit_idx_c;
            empty_reg     <= empty_c;
            empty_idx_reg <= empty_idx_c;
            lru_idx_reg   <= lru_idx_c;
            step_reg      <= step_c;
            quot_reg      <= prod_c[atc_pkg::PROD_W-1:atc_pkg::MOD_SHIFT];
        end
        if (cmd.update)
        begin
            status_reg <= status_next;
            slot_reg   <= atc_pkg::SLOT_W'(slot_next);
            evict_reg  <= evict_next;
        end
    end

    assign rsp_status     = 3'(status_reg);
    assign rsp_slot       = slot_reg;
    assign rsp_evicted_id = evict_reg;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ============================================================================
// Testbench for the associative tag cache
// Drives store and retrieve requests through the request channel, predicts
// each unpinned response with a mirror of the slot, recency and victim
// state, and checks every response in order. It starts with a short directed
// table and continues with random phases in both replacement modes, with
// random idling on both sides, a long response hold-off and a sender pause.
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atc_pkg::*;

    localparam int                CYCLE_LIMIT = 200000;
    localparam int                HOLD_CYCLES = 300;
    localparam int                POOL_SIZE   = 24;
    localparam logic [ID_W-1:0]   ID_MAX      = '1;

    // One response as it is seen on the response channel.
    typedef struct packed {
        atc_status_t        status;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    evicted_id;
    } cache_rsp_t;

    // One row of the directed table; pinned rows carry a hand-written response.
    typedef struct {
        logic               op;
        logic [ID_W-1:0]    id;
        bit                 pinned;
        cache_rsp_t         rsp;
    } directed_row_t;

    logic clk;
    logic rst_n;

    atc_req_if req_ch ();
    atc_rsp_if rsp_ch ();
    atc_cfg_if cfg_ch ();

    assoc_tag_cache_lru_random u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Mirror of the cache state.
    bit                 mir_valid [ENTRIES];
    logic [ID_W-1:0]    mir_id    [ENTRIES];
    logic [RANK_W-1:0]  mir_rank  [ENTRIES];
    logic [LFSR_W-1:0]  mir_lfsr;
    logic               mir_mode;

    cache_rsp_t         owed_responses [$];
    cache_rsp_t         oldest_owed;
    cache_rsp_t         mirror_rsp;
    directed_row_t      script [$];
    logic [ID_W-1:0]    id_pool [POOL_SIZE];

    // Hand-written response travelling with the request on the channel.
    bit                 pin_flag;
    cache_rsp_t         pin_rsp;

    int                 cycle_count;
    int                 error_count;
    bit                 quiet;
    bit                 hold_req;

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Makes slot s the most recently used, ageing the slots that were younger.
    function automatic void mirror_touch(input int s);
        bit was_valid;
        was_valid = mir_valid[s];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && mir_valid[i] && (!was_valid || mir_rank[i] < mir_rank[s]))
            begin
                mir_rank[i] = mir_rank[i] + 1'b1;
            end
        end
        mir_rank[s]  = '0;
        mir_valid[s] = 1'b1;
    endfunction

    // Works out the response to one request and updates the mirror.
    function automatic cache_rsp_t cache_mirror_access(input logic op,
                                                       input logic [ID_W-1:0] id);
        cache_rsp_t        rsp;
        int                hit_slot;
        int                free_slot;
        int                victim;
        logic              feedback;
        hit_slot  = -1;
        free_slot = -1;
        rsp       = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_slot < 0 && mir_valid[i] && mir_id[i] == id)
            begin
                hit_slot = i;
            end
            if (free_slot < 0 && !mir_valid[i])
            begin
                free_slot = i;
            end
        end

        if (op == OP_RETRIEVE)
        begin
            if (hit_slot >= 0)
            begin
                mirror_touch(hit_slot);
                rsp.status = ST_HIT;
                rsp.slot   = SLOT_W'(hit_slot);
            end
            else
            begin
                rsp.status = ST_MISS;
            end
        end
        else if (hit_slot >= 0)
        begin
            mirror_touch(hit_slot);
            rsp.status = ST_REFRESHED;
            rsp.slot   = SLOT_W'(hit_slot);
        end
        else if (free_slot >= 0)
        begin
            mir_id[free_slot] = id;
            mirror_touch(free_slot);
            rsp.status = ST_STORED;
            rsp.slot   = SLOT_W'(free_slot);
        end
        else
        begin
            // Every slot is full, so a victim is chosen by the current mode.
            if (mir_mode)
            begin
                feedback = mir_lfsr[0];
                mir_lfsr = mir_lfsr >> 1;
                if (feedback)
                begin
                    mir_lfsr = mir_lfsr ^ LFSR_TAPS;
                end
                victim = int'(mir_lfsr) % ENTRIES;
            end
            else
            begin
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                begin
                    if (mir_rank[i] > mir_rank[victim])
                    begin
                        victim = i;
                    end
                end
            end
            rsp.status     = ST_EVICTED;
            rsp.slot       = SLOT_W'(victim);
            rsp.evicted_id = mir_id[victim];
            mir_id[victim] = id;
            mirror_touch(victim);
        end
        return rsp;
    endfunction

    // Watches all three channels at the rising edge and checks responses.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                mir_valid[i] = 1'b0;
                mir_id[i]    = '0;
                mir_rank[i]  = '0;
            end
            mir_lfsr = LFSR_SEED;
            mir_mode = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_responses.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d slot %0d",
                           rsp_ch.status, rsp_ch.slot);
                    error_count++;
                end
                else
                begin
                    oldest_owed = owed_responses.pop_front();
                    if (rsp_ch.status !== oldest_owed.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_owed.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.slot !== oldest_owed.slot)
                    begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               oldest_owed.slot, rsp_ch.slot);
                        error_count++;
                    end
                    if (rsp_ch.evicted_id !== oldest_owed.evicted_id)
                    begin
                        $error("evicted_id mismatch: expected %0h, actual %0h",
                               oldest_owed.evicted_id, rsp_ch.evicted_id);
                        error_count++;
                    end
                end
            end

            if (req_ch.valid && req_ch.ready)
            begin
                mirror_rsp = cache_mirror_access(req_ch.operation, req_ch.message_id);
                owed_responses.push_back(pin_flag ? pin_rsp : mirror_rsp);
            end

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                mir_mode = cfg_ch.replace_mode;
            end
        end
    end

    // Response side: random back-pressure, quiet stretches and a long hold-off.
    initial
    begin : rsp_driver
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (quiet)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= 10);
            end
        end
    end

    function automatic directed_row_t make_row(input logic op, input logic [ID_W-1:0] id,
                                               input bit pinned, input atc_status_t st,
                                               input logic [SLOT_W-1:0] sl,
                                               input logic [ID_W-1:0] ev);
        directed_row_t row;
        row.op             = op;
        row.id             = id;
        row.pinned         = pinned;
        row.rsp.status     = st;
        row.rsp.slot       = sl;
        row.rsp.evicted_id = ev;
        return row;
    endfunction

    // Fresh set of identifiers to draw from, with both extremes included.
    function automatic void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i] = ID_W'($urandom);
        end
        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
    endfunction

    // Mostly identifiers from the pool, some near misses and some fresh ones.
    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            return id_pool[$urandom_range(POOL_SIZE - 1)];
        end
        else if (roll < 85)
        begin
            return id_pool[$urandom_range(POOL_SIZE - 1)] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
        end
        return ID_W'($urandom);
    endfunction

    // Offers one request; called and returning at a falling edge.
    task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                             input bit pinned, input cache_rsp_t pinned_rsp);
        if (!quiet)
        begin
            while ($urandom_range(99) < 10)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.message_id <= id;
        pin_flag          <= pinned;
        pin_rsp           <= pinned_rsp;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_item(logic'($urandom_range(1)), pick_id(), 1'b0, '0);
        end
    endtask

    // Stops offering and waits until every outstanding request has answered.
    task automatic settle();
        req_ch.valid <= 1'b0;
        pin_flag     <= 1'b0;
        while (owed_responses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.replace_mode <= mode;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Main sequence: reset, directed table, then random phases in both modes.
    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_STORE;
        req_ch.message_id   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.replace_mode = 1'b0;
        pin_flag            = 1'b0;
        pin_rsp             = '0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        cycle_count         = 0;
        error_count         = 0;
        rst_n               = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_mode(1'b0);

        // An empty cache misses; the first stores fill the lowest slots.
        script.push_back(make_row(OP_RETRIEVE, '0, 1'b1, ST_MISS, SLOT_W'(0), '0));
        script.push_back(make_row(OP_RETRIEVE, ID_MAX, 1'b1, ST_MISS, SLOT_W'(0), '0));
        script.push_back(make_row(OP_STORE, '0, 1'b1, ST_STORED, SLOT_W'(0), '0));
        script.push_back(make_row(OP_STORE, ID_MAX, 1'b1, ST_STORED, SLOT_W'(1), '0));
        script.push_back(make_row(OP_RETRIEVE, '0, 1'b1, ST_HIT, SLOT_W'(0), '0));
        script.push_back(make_row(OP_STORE, ID_MAX, 1'b1, ST_REFRESHED, SLOT_W'(1), '0));
        script.push_back(make_row(OP_RETRIEVE, ID_MAX, 1'b0, ST_HIT, SLOT_W'(0), '0));
        // Fill the remaining slots with alternating bit patterns.
        for (int k = 2; k < ENTRIES; k++)
        begin
            script.push_back(make_row(OP_STORE,
                                      ((k % 2) ? 31'h5555_5500 : 31'h2AAA_AA00) + ID_W'(k),
                                      1'b0, ST_STORED, SLOT_W'(0), '0));
        end
        // A full cache evicts its oldest slot; the evicted identifier then misses.
        script.push_back(make_row(OP_STORE, 31'h0000_1234, 1'b0, ST_EVICTED, SLOT_W'(0), '0));
        script.push_back(make_row(OP_RETRIEVE, '0, 1'b1, ST_MISS, SLOT_W'(0), '0));
        script.push_back(make_row(OP_RETRIEVE, 31'h2AAA_AA02, 1'b0, ST_HIT, SLOT_W'(0), '0));
        script.push_back(make_row(OP_STORE, 31'h4000_0001, 1'b0, ST_EVICTED, SLOT_W'(0), '0));
        foreach (script[i])
        begin
            send_item(script[i].op, script[i].id, script[i].pinned, script[i].rsp);
        end
        settle();

        // Random victims, with a long response hold-off part way through.
        write_mode(1'b1);
        refill_pool();
        run_random(200);
        hold_req <= 1'b1;
        run_random(40);
        settle();

        // Least recently used, starting with a stretch without any idling.
        write_mode(1'b0);
        refill_pool();
        quiet <= 1'b1;
        run_random(150);
        quiet <= 1'b0;
        run_random(100);
        settle();

        write_mode(1'b1);
        refill_pool();
        run_random(200);
        settle();

        write_mode(1'b0);
        run_random(200);
        settle();

        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/atc_pkg.sv
rtl/atc_if.sv
rtl/atc_ctrl.sv
rtl/atc_dp.sv
rtl/assoc_tag_cache_lru_random.sv
dv/tb.sv
